>>> design/ilms_pkg.sv
// ilms_pkg: shared types and constants for the interval list membership search.
// Used by ilms_ctrl, ilms_dpath and interval_list_membership_search.
package ilms_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int KEY_WIDTH   = 64;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int POS_W       = 10;
    localparam int CFG_IDX_W   = 1;
    // signed search bounds: low may pass the top by one, high may drop to -1
    localparam int SPAN_W      = POS_W + 2;
    // pair tests allowed per query: floor(log2(depth)) + 2
    localparam int PROBE_LIMIT = $clog2(TABLE_DEPTH + 1) + 1;
    localparam int LEFT_W      = $clog2(PROBE_LIMIT + 1);

    localparam logic [POS_W-1:0] RANGE_FIRST_RST = POS_W'(0);
    localparam logic [POS_W-1:0] RANGE_LAST_RST  = POS_W'(1023);

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_FIRST = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LAST  = CFG_IDX_W'(1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_TEST,
        S_DONE
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load_wr;   // write accepted bound word
        logic start;     // latch query and range
        logic issue;     // read probe pair
        logic miss;      // stop with not found
        logic test;      // compare pair, narrow range or finish
        logic out_load;  // move answer into output register
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic stop;      // empty range or probe budget spent
        logic test_end;  // pair holds key, or last possible pair
        logic out_free;  // output register can take a word
    } t_dp_sts;

endpackage

>>> design/ilms_ctrl.sv
// ilms_ctrl: search sequencer (idle, issue read, test pair, hand off result).
// Depends on ilms_pkg.
module ilms_ctrl
    import ilms_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_in_cmd,
    input  t_dp_sts i_sts,
    output logic    o_in_ready,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_in_cmd == CMD_QUERY) begin
                    n_state = S_ISSUE;
                end
            end
            S_ISSUE: begin
                n_state = i_sts.stop ? S_DONE : S_TEST;
            end
            S_TEST: begin
                n_state = i_sts.test_end ? S_DONE : S_ISSUE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.load_wr = i_in_valid && i_in_cmd == CMD_LOAD;
                o_cmd.start   = i_in_valid && i_in_cmd == CMD_QUERY;
            end
            S_ISSUE: begin
                o_cmd.issue = !i_sts.stop;
                o_cmd.miss  = i_sts.stop;
            end
            S_TEST: begin
                o_cmd.test = 1'b1;
            end
            S_DONE: begin
                o_cmd.out_load = i_sts.out_free;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

>>> design/ilms_dpath.sv
// ilms_dpath: bound table, range registers, search bounds, pair compare, output register.
// Depends on ilms_pkg.
module ilms_dpath
    import ilms_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    output t_dp_sts              o_sts,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [POS_W-1:0]     i_cfg_data,
    input  logic [POS_W-1:0]     i_load_position,
    input  logic [KEY_WIDTH-1:0] i_load_bound,
    input  logic [KEY_WIDTH-1:0] i_query_key,
    input  logic                 i_final_query,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic                 o_found,
    output logic                 o_final_result
);

    logic [KEY_WIDTH-1:0] r_mem [TABLE_DEPTH];

    logic [POS_W-1:0]        r_range_first;
    logic [POS_W-1:0]        r_range_last;
    logic signed [SPAN_W-1:0] r_lo;
    logic signed [SPAN_W-1:0] r_hi;
    logic signed [SPAN_W-1:0] r_mid;
    logic [LEFT_W-1:0]       r_left;
    logic                    r_last_pair;
    logic [KEY_WIDTH-1:0]    r_key;
    logic                    r_final;
    logic                    r_found;
    logic [KEY_WIDTH-1:0]    r_word_a;
    logic [KEY_WIDTH-1:0]    r_word_b;
    logic                    r_out_valid;
    logic                    r_out_found;
    logic                    r_out_last;

    logic signed [SPAN_W-1:0] span;
    logic signed [SPAN_W-1:0] mid;
    logic [ADDR_W-1:0]        addr_a;
    logic [ADDR_W-1:0]        addr_b;
    logic                     hit;
    logic                     below;

    // round state
    always_comb begin
        span   = r_hi - r_lo;
        mid    = r_lo + (span >>> 1);
        mid[0] = 1'b0;
        if (span == SPAN_W'(1)) begin
            addr_a = r_lo[ADDR_W-1:0];
            addr_b = r_hi[ADDR_W-1:0];
        end else begin
            addr_a = mid[ADDR_W-1:0];
            addr_b = addr_a | ADDR_W'(1);
        end
    end

    assign hit   = (r_key == r_word_a) || (r_key == r_word_b) ||
                   ((r_word_a < r_key) && (r_word_b > r_key));
    assign below = r_key < r_word_a;

    assign o_sts.stop     = (span < SPAN_W'(1)) || (r_left == '0);
    assign o_sts.test_end = hit || r_last_pair;
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    // table: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_wr) begin
            r_mem[i_load_position[ADDR_W-1:0]] <= i_load_bound[KEY_WIDTH-1:0];
        end
        if (i_cmd.issue) begin
            r_word_a <= r_mem[addr_a];
            r_word_b <= r_mem[addr_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_first <= RANGE_FIRST_RST;
            r_range_last  <= RANGE_LAST_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_RANGE_FIRST: r_range_first <= i_cfg_data;
                CFG_RANGE_LAST:  r_range_last  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_lo    <= SPAN_W'(r_range_first);
            r_hi    <= SPAN_W'(r_range_last);
            r_left  <= LEFT_W'(PROBE_LIMIT);
            r_key   <= i_query_key[KEY_WIDTH-1:0];
            r_final <= i_final_query;
        end
        if (i_cmd.issue) begin
            r_mid       <= mid;
            r_last_pair <= span == SPAN_W'(1);
            r_left      <= r_left - LEFT_W'(1);
        end
        if (i_cmd.miss) begin
            r_found <= 1'b0;
        end
        if (i_cmd.test) begin
            r_found <= hit;
            if (below) begin
                r_hi <= r_mid - SPAN_W'(1);
            end else begin
                r_lo <= r_mid + SPAN_W'(2);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_found <= r_found;
            r_out_last  <= r_final;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_found        = r_out_found;
    assign o_final_result = r_out_last;

endmodule

>>> design/interval_list_membership_search.sv
// Flow: a query word is searched by alternating a pair read and a pair test until a pair test
// ends the search, the range empties or the 12-test budget runs out; its result then goes to
// the output register. Queries are taken one at a time, and the input stays stalled while the
// result word waits on tready. Each test is a two-port table read plus a 64-bit compare and
// bound update. A load word is written as it is accepted and gives no result.
// Reset (sync, active low) clears sequencer, output valid and range regs (first 0, last 1023).
module interval_list_membership_search
    import ilms_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // [9:0] load_position, [73:10] load_bound, [137:74] query_key, [143:138] zero
    input  logic [143:0]         s_axis_tdata,
    // [0] cmd: 0 load bound word, 1 query
    input  logic                 s_axis_tuser,
    // final_query
    input  logic                 s_axis_tlast,
    // result stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [0] found, [7:1] zero
    output logic [7:0]           m_axis_tdata,
    // final_result
    output logic                 m_axis_tlast,
    // configuration: 0 range_first, 1 range_last
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [POS_W-1:0]     i_cfg_data
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;
    logic    found;

    // The sequencer takes one word at a time; loads retire in the accept cycle,
    // queries hold the input until their answer sits in the output register.
    ilms_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_cmd   (s_axis_tuser),
        .i_sts      (dp_sts),
        .o_in_ready (s_axis_tready),
        .o_cmd      (dp_cmd)
    );

    // Binary search over pair boundaries; mid rounded down to an even position.
    ilms_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .o_sts           (dp_sts),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_load_position (s_axis_tdata[9:0]),
        .i_load_bound    (s_axis_tdata[73:10]),
        .i_query_key     (s_axis_tdata[137:74]),
        .i_final_query   (s_axis_tlast),
        .i_out_ready     (m_axis_tready),
        .o_out_valid     (m_axis_tvalid),
        .o_found         (found),
        .o_final_result  (m_axis_tlast)
    );

    assign m_axis_tdata = {7'b0, found};

endmodule

>>> bench/ilms_scoreboard_pkg.sv
// ilms_scoreboard_pkg: expected-result store and search predictor for the bench.
// Depends on ilms_pkg for table depth, key width and command codes.
package ilms_scoreboard_pkg;
    import ilms_pkg::*;

    typedef struct packed {
        bit found;
        bit is_last;
    } t_answer;

    class interval_scoreboard;
        bit [KEY_WIDTH-1:0] bounds [TABLE_DEPTH];
        // entry holds the value of the current interval plan
        bit                 current [TABLE_DEPTH];
        bit [POS_W-1:0]     first_pos;
        bit [POS_W-1:0]     last_pos;
        t_answer            pending [$];
        int                 errors;
        int                 checked;
        int                 hits;

        function new();
            first_pos = RANGE_FIRST_RST;
            last_pos  = RANGE_LAST_RST;
        endfunction

        function void restart_plan();
            foreach (current[i]) current[i] = 1'b0;
        endfunction

        local function bit [KEY_WIDTH-1:0] word_at(int pos, inout int stale);
            if (pos < 0 || pos >= TABLE_DEPTH) begin
                return '0;
            end
            if (!current[pos] && stale < 0) begin
                stale = pos;
            end
            return bounds[pos];
        endfunction

        local function bit pair_has(int a, int b, bit [KEY_WIDTH-1:0] k, inout int stale);
            bit [KEY_WIDTH-1:0] lo_w;
            bit [KEY_WIDTH-1:0] hi_w;
            lo_w = word_at(a, stale);
            hi_w = word_at(b, stale);
            return (k == lo_w) || (k == hi_w) || (lo_w < k && k < hi_w);
        endfunction

        // Binary search over pairs; stale is the first probed entry that is not
        // part of the current plan (-1 if none).
        function bit member(bit [KEY_WIDTH-1:0] k, output int stale);
            int lo;
            int hi;
            int d;
            int mid;
            stale = -1;
            lo    = first_pos;
            hi    = last_pos;
            for (int tests = 0; tests < PROBE_LIMIT; tests++) begin
                d = hi - lo;
                if (d < 1) begin
                    return 1'b0;
                end
                if (d == 1) begin
                    return pair_has(lo, hi, k, stale);
                end
                mid = (lo + d / 2) & ~1;
                if (pair_has(mid, mid + 1, k, stale)) begin
                    return 1'b1;
                end
                if (k < word_at(mid, stale)) begin
                    hi = mid - 1;
                end else begin
                    lo = mid + 2;
                end
            end
            return 1'b0;
        endfunction

        function void note_word(bit cmd, bit [POS_W-1:0] pos, bit [KEY_WIDTH-1:0] bound,
                                bit [KEY_WIDTH-1:0] key, bit is_last);
            int      stale;
            t_answer want;
            if (cmd == CMD_LOAD) begin
                bounds[pos] = bound;
            end else begin
                want.found   = member(key, stale);
                want.is_last = is_last;
                pending.push_back(want);
            end
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= 10) begin
                $display("MISMATCH: %s", msg);
            end
        endfunction

        function void check_result(logic found, logic is_last);
            t_answer want;
            if (pending.size() == 0) begin
                flag($sformatf("result found=%b last=%b with nothing pending", found, is_last));
                return;
            end
            want = pending.pop_front();
            checked++;
            hits += want.found;
            if (want.found !== found) begin
                flag($sformatf("result %0d found: expected %b, got %b",
                               checked, want.found, found));
            end
            if (want.is_last !== is_last) begin
                flag($sformatf("result %0d last: expected %b, got %b",
                               checked, want.is_last, is_last));
            end
        endfunction

        function void close();
            if (pending.size() != 0) begin
                errors += pending.size();
                $display("MISMATCH: %0d results never arrived", pending.size());
            end
        endfunction
    endclass

endpackage

>>> bench/tb_top.sv
// tb_top: self-checking bench for interval_list_membership_search.
// Streams bound loads and key queries, predicts each answer in ilms_scoreboard_pkg.
// Depends on ilms_pkg and ilms_scoreboard_pkg.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ilms_pkg::*;
    import ilms_scoreboard_pkg::*;

    localparam int ITEMS        = 1550;
    localparam int DRAIN_CYCLES = 32;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam bit [KEY_WIDTH-1:0] KEY_MAX = '1;

    typedef enum int { RX_OPEN, RX_HOLD, RX_JITTER } t_rx_mode;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    // [9:0] load_position, [73:10] load_bound, [137:74] query_key, [143:138] zero
    logic [143:0]         s_axis_tdata;
    logic                 s_axis_tuser;    // cmd
    logic                 s_axis_tlast;    // final_query
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    // [0] found, [7:1] zero
    logic [7:0]           m_axis_tdata;
    logic                 m_axis_tlast;    // final_result
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [POS_W-1:0]     i_cfg_data;

    interval_list_membership_search i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    interval_scoreboard sb = new();

    // Intended table contents for the current phase; entries are loaded
    // lazily, right before a query would probe them.
    bit [KEY_WIDTH-1:0] plan [TABLE_DEPTH];

    int          words_sent;
    int          loads_sent;
    int          queries_sent;
    int          phase;
    int          burst_left;
    bit          gaps_on = 1'b1;
    int unsigned cycles;

    always #6 i_clk = ~i_clk;

    // Watchdog: a hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycles, sb.pending.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // Result monitor: sampled at the rising edge, before the block updates.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_result(m_axis_tdata[0], m_axis_tlast);
        end
    end

    // Receiver back-pressure: segments of open, held and jittery tready.
    initial begin
        t_rx_mode rx_mode;
        int       seg_left;
        rx_mode       = RX_OPEN;
        seg_left      = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (seg_left == 0) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: begin
                        rx_mode  = RX_OPEN;
                        seg_left = $urandom_range(1, 60);
                    end
                    4, 5, 6: begin
                        rx_mode  = RX_HOLD;
                        seg_left = $urandom_range(1, 12);
                    end
                    default: begin
                        rx_mode  = RX_JITTER;
                        seg_left = $urandom_range(8, 40);
                    end
                endcase
            end
            seg_left--;
            case (rx_mode)
                RX_OPEN: m_axis_tready = 1'b1;
                RX_HOLD: m_axis_tready = 1'b0;
                default: m_axis_tready = ($urandom_range(0, 1) != 0);
            endcase
        end
    end

    // One word onto the input stream. Bursts of back-to-back words are split
    // by random gaps unless gaps are off for the phase; tvalid stays high
    // across a burst.
    task automatic send_word(bit cmd, bit [POS_W-1:0] pos, bit [KEY_WIDTH-1:0] bound,
                             bit [KEY_WIDTH-1:0] key, bit is_last);
        @(negedge i_clk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            if (gaps_on) begin
                s_axis_tvalid = 1'b0;
                if ($urandom_range(0, 4) == 0) begin
                    repeat ($urandom_range(9, 40)) @(negedge i_clk);
                end else begin
                    repeat ($urandom_range(1, 8)) @(negedge i_clk);
                end
            end
        end
        burst_left--;
        s_axis_tuser  = cmd;
        s_axis_tlast  = is_last;
        s_axis_tdata  = {6'b0, key, bound, pos};
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_word(cmd, pos, bound, key, is_last);
        words_sent++;
        if (cmd == CMD_LOAD) begin
            loads_sent++;
        end else begin
            queries_sent++;
        end
    endtask

    // Load word: the query fields are don't-care and get random content.
    task automatic load_word(bit [POS_W-1:0] pos, bit [KEY_WIDTH-1:0] bound);
        send_word(CMD_LOAD, pos, bound, {$urandom, $urandom}, $urandom_range(0, 1) != 0);
    endtask

    task automatic load_plan(int pos);
        load_word(POS_W'(pos), plan[pos]);
        sb.current[pos] = 1'b1;
    endtask

    // Query word. Every entry on the search path that is not marked current is
    // loaded from the plan first, so no probe ever hits a never-written entry.
    task automatic ask(bit [KEY_WIDTH-1:0] key, bit is_last);
        int stale;
        void'(sb.member(key, stale));
        while (stale >= 0) begin
            load_plan(stale);
            void'(sb.member(key, stale));
        end
        send_word(CMD_QUERY, POS_W'($urandom), {$urandom, $urandom}, key, is_last);
    endtask

    // Hold the sender until every pending result is back, then let the
    // pipeline run empty (a trailing load leaves no result behind).
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        burst_left    = 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_range(bit [POS_W-1:0] first_pos, bit [POS_W-1:0] last_pos);
        drain();
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = CFG_RANGE_FIRST;
        i_cfg_data = first_pos;
        @(negedge i_clk);
        i_cfg_idx  = CFG_RANGE_LAST;
        i_cfg_data = last_pos;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        sb.first_pos = first_pos;
        sb.last_pos  = last_pos;
    endtask

    // Sorted plan: non-decreasing bounds with a random step scale (zero steps
    // give degenerate and repeated intervals). Unsorted plan: random words.
    function automatic void make_plan(bit sorted);
        bit [KEY_WIDTH-1:0] w;
        bit [KEY_WIDTH-1:0] span;
        span = (64'd1 << $urandom_range(1, 53)) - 64'd1;
        w    = ($urandom_range(0, 3) == 0) ? '0 : ({$urandom, $urandom} >> $urandom_range(1, 63));
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (sorted) begin
                plan[i] = w;
                w += ({$urandom, $urandom} & span) + 64'(($urandom_range(0, 7) != 0));
            end else begin
                plan[i] = {$urandom, $urandom};
            end
        end
        sb.restart_plan();
    endfunction

    initial begin
        int                 phase_len;
        int                 lo_p;
        int                 hi_p;
        int                 p;
        bit [KEY_WIDTH-1:0] a;
        bit [KEY_WIDTH-1:0] b;
        bit [KEY_WIDTH-1:0] key;
        bit [POS_W-1:0]     f;
        bit [POS_W-1:0]     l;

        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_LOAD;
        s_axis_tlast  = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = CFG_RANGE_FIRST;
        i_cfg_data    = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // ---- directed part ----
        make_plan(1'b1);
        // Small hand-made table in positions 0..7: [0,5] [10,10] [20,30] [40,max]
        plan[0] = '0;
        plan[1] = 64'd5;
        plan[2] = 64'd10;
        plan[3] = 64'd10;
        plan[4] = 64'd20;
        plan[5] = 64'd30;
        plan[6] = 64'd40;
        plan[7] = KEY_MAX;

        // Range after reset is 0..1023: first probe is the pair 510/511.
        ask(plan[510], 1'b0);
        ask(plan[511], 1'b1);

        set_range(10'd0, 10'd7);
        ask(64'd0, 1'b0);       // lowest key, equals a start bound
        ask(KEY_MAX, 1'b0);     // highest key, equals an end bound
        ask(64'd3, 1'b0);       // strictly inside
        ask(64'd7, 1'b0);       // gap between intervals
        ask(64'd10, 1'b0);      // single-point interval
        ask(64'd25, 1'b0);
        ask(64'd35, 1'b1);      // gap, closes the batch

        load_word(10'h3FF, KEY_MAX);   // top position

        set_range(10'd4, 10'd4);       // empty range
        ask(64'd10, 1'b0);
        set_range(10'd5, 10'd2);       // inverted range
        ask(64'd10, 1'b1);
        set_range(10'd2, 10'd3);       // exactly one pair
        ask(64'd10, 1'b0);
        ask(64'd11, 1'b1);

        // ---- random part ----
        phase = 0;
        while (words_sent < ITEMS) begin
            case (phase)
                0: begin f = 10'd0;    l = 10'd1023; end
                1: begin f = 10'd0;    l = 10'd1;    end
                2: begin f = 10'd1022; l = 10'd1023; end
                3: begin f = 10'd1023; l = 10'd0;    end
                4: begin f = 10'd1023; l = 10'd1023; end
                5: begin f = 10'd7;    l = 10'd600;  end
                6: begin f = 10'd0;    l = 10'd0;    end
                7: begin f = 10'd512;  l = 10'd1023; end
                default: begin
                    f = POS_W'($urandom);
                    l = POS_W'($urandom);
                    // mostly well-formed: even start, odd end, ordered
                    if ($urandom_range(0, 4) != 0) begin
                        if (l < f) begin
                            {f, l} = {l, f};
                        end
                        f[0] = 1'b0;
                        l[0] = 1'b1;
                    end
                end
            endcase
            set_range(f, l);
            if (phase == 0 || $urandom_range(0, 2) == 0) begin
                make_plan($urandom_range(0, 5) != 0);
            end
            gaps_on   = ($urandom_range(0, 4) != 0);
            phase_len = $urandom_range(20, 60);

            repeat (phase_len) begin
                if (words_sent >= ITEMS) break;
                case ($urandom_range(0, 19))
                    0: load_word(POS_W'($urandom), {$urandom, $urandom});   // noise
                    1: load_plan($urandom_range(0, TABLE_DEPTH - 1));
                    2: drain();
                    default: begin
                        // key near a plan bound inside (or just below) the range
                        lo_p = (sb.first_pos == 0) ? 0 : int'(sb.first_pos) - 1;
                        hi_p = sb.last_pos;
                        if (hi_p < lo_p) begin
                            lo_p = 0;
                            hi_p = TABLE_DEPTH - 1;
                        end
                        p = $urandom_range(hi_p, lo_p);
                        a = plan[p];
                        b = plan[(p < TABLE_DEPTH - 1) ? p + 1 : p];
                        case ($urandom_range(0, 9))
                            0: key = {$urandom, $urandom};
                            1: key = ($urandom_range(0, 1) != 0) ? KEY_MAX : '0;
                            2: key = a;
                            3: key = a - 64'd1;
                            4: key = a + 64'd1;
                            5: key = b;
                            6: key = b + 64'd1;
                            default: key = (b > a) ? a + ({$urandom, $urandom} % (b - a)) : a;
                        endcase
                        ask(key, $urandom_range(0, 3) == 0);
                    end
                endcase
            end
            phase++;
        end

        // ---- wind-down ----
        drain();
        sb.close();
        $display("Summary: %0d words (%0d bound loads, %0d queries), %0d results checked, %0d hits",
                 words_sent, loads_sent, queries_sent, sb.checked, sb.hits);
        $display("Summary: %0d range settings incl. empty, inverted, single-pair and full range",
                 phase + 4);
        if (sb.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
